// File: src/grid_slope_limit_raise_total_unit_assert.svh
// Assertion macros shared by the grid slope limit modules.
// Included by the sweep controller and the relaxation datapath; no other dependencies.
`ifndef GRID_SLOPE_LIMIT_RAISE_TOTAL_UNIT_ASSERT_SVH
`define GRID_SLOPE_LIMIT_RAISE_TOTAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GSLRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GSLRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GSLRT_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define GSLRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/gslrt_pkg.sv
// Shared constants and types for the grid slope limit raise total unit.
// No dependencies; used by the controller, the datapath and the top level.
package gslrt_pkg;

   localparam int MAX_ROWS_DEFAULT    = 64;
   localparam int MAX_COLS_DEFAULT    = 64;
   localparam int HEIGHT_BITS_DEFAULT = 20;

   localparam int CELL_HEIGHT_BITS = 20;
   localparam int TOTAL_BITS       = 32;
   localparam int CSR_DATA_BITS    = 7;
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLS_IN_USE = 2'd1;

   localparam logic [CSR_DATA_BITS-1:0] ROWS_RESET = 7'd64;
   localparam logic [CSR_DATA_BITS-1:0] COLS_RESET = 7'd64;

   // Control that travels with the grid read data into the relaxation stage.
   typedef struct packed {
      logic valid;       // a cell is being relaxed this cycle
      logic backward;    // backward pass: also accumulate the raise
      logic has_a;       // the previous cell in scan order is a neighbor
      logic has_b;       // the row neighbor (up or down) exists
      logic nb_is_last;  // single column: the row neighbor is the previous cell
      logic sum_clear;   // start of the backward pass
   } stage_type;

endpackage

// File: src/gslrt_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module gslrt_ram #(
   parameter int WIDTH     = 40,
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   output logic [WIDTH-1:0]     rd_data_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: src/gslrt_ctrl.sv
// Sweep controller: size registers, loading counters and the forward and
// backward raster passes over the grid memory. Depends on gslrt_pkg.
`include "grid_slope_limit_raise_total_unit_assert.svh"

module gslrt_ctrl #(
   parameter int MAX_ROWS  = gslrt_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS  = gslrt_pkg::MAX_COLS_DEFAULT,
   parameter int ADDR_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gslrt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gslrt_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                                start,
   output logic                                busy,
   output logic                                load_we,
   output logic [ADDR_BITS-1:0]                issue_addr,
   output logic [ADDR_BITS-1:0]                nb_addr,
   output gslrt_pkg::stage_type                stage,
   output logic [ADDR_BITS-1:0]                stage_addr,
   output logic                                rsp_valid
);

   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int AXW = ADDR_BITS + 1;

   typedef enum logic [2:0] {ST_LOAD, ST_FWD, ST_GAP, ST_BWD, ST_FLUSH} state_type;

   state_type state_ff, state_in;
   logic [gslrt_pkg::CSR_DATA_BITS-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in, last_addr_ff, last_addr_in;
   logic [ADDR_BITS-1:0] stage_addr_ff;
   gslrt_pkg::stage_type stage_ff, stage_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [RW-1:0]  rows_eff, rows_last;
   logic [CW-1:0]  cols_eff, cols_last;
   logic           row_is_last, col_is_last, cols_one, cfg_hit;
   logic [AXW-1:0] addr_x, cols_x, up_x, down_x;

   // Out-of-range sizes: zero counts as one, anything above the maximum as the maximum.
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_ff);
      end
   end

   assign rows_last   = rows_eff - RW'(1);
   assign cols_last   = cols_eff - CW'(1);
   assign row_is_last = (row_ff == rows_last);
   assign col_is_last = (col_ff == cols_last);
   assign cols_one    = (cols_eff == CW'(1));
   assign cfg_hit     = csr_wr_en && (csr_index == gslrt_pkg::REG_ROWS_IN_USE ||
                                      csr_index == gslrt_pkg::REG_COLS_IN_USE);

   assign addr_x = AXW'(addr_ff);
   assign cols_x = AXW'(cols_eff);
   assign up_x   = addr_x - cols_x;
   assign down_x = addr_x + cols_x;

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      last_addr_in = last_addr_ff;
      stage_in     = '0;
      rsp_valid_in = (state_ff == ST_FLUSH);
      load_we      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               load_we = 1'b1;
               if (row_is_last && col_is_last) begin
                  last_addr_in = addr_ff;
                  state_in     = ST_FWD;
                  row_in       = '0;
                  col_in       = '0;
                  addr_in      = '0;
               end else begin
                  if (col_is_last) begin
                     col_in = '0;
                     row_in = row_ff + RW'(1);
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
                  addr_in = addr_ff + ADDR_BITS'(1);
               end
            end
         end
         ST_FWD: begin
            stage_in.valid      = 1'b1;
            stage_in.has_a      = (col_ff != '0);
            stage_in.has_b      = (row_ff != '0);
            stage_in.nb_is_last = cols_one;
            if (row_is_last && col_is_last) begin
               state_in = ST_GAP;
               row_in   = rows_last;
               col_in   = cols_last;
               addr_in  = last_addr_ff;
            end else begin
               if (col_is_last) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
               addr_in = addr_ff + ADDR_BITS'(1);
            end
         end
         ST_GAP: begin
            // The last forward cell is written back during this cycle.
            stage_in.sum_clear = 1'b1;
            state_in           = ST_BWD;
         end
         ST_BWD: begin
            stage_in.valid      = 1'b1;
            stage_in.backward   = 1'b1;
            stage_in.has_a      = !col_is_last;
            stage_in.has_b      = !row_is_last;
            stage_in.nb_is_last = cols_one;
            if (row_ff == '0 && col_ff == '0) begin
               state_in = ST_FLUSH;
               addr_in  = '0;
            end else begin
               if (col_ff == '0) begin
                  col_in = cols_last;
                  row_in = row_ff - RW'(1);
               end else begin
                  col_in = col_ff - CW'(1);
               end
               addr_in = addr_ff - ADDR_BITS'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // A size write drops any partial data set.
      if (cfg_hit) begin
         state_in = ST_LOAD;
         row_in   = '0;
         col_in   = '0;
         addr_in  = '0;
         if (csr_index == gslrt_pkg::REG_ROWS_IN_USE) begin
            rows_in = csr_wr_data;
         end else begin
            cols_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rows_ff      <= gslrt_pkg::ROWS_RESET;
         cols_ff      <= gslrt_pkg::COLS_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         addr_ff      <= '0;
         last_addr_ff <= '0;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         addr_ff      <= addr_in;
         last_addr_ff <= last_addr_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stage_addr_ff <= addr_ff;
   end

   assign busy       = (state_ff != ST_LOAD);
   assign issue_addr = addr_ff;
   assign nb_addr    = (state_ff == ST_BWD) ? down_x[ADDR_BITS-1:0] : up_x[ADDR_BITS-1:0];
   assign stage      = stage_ff;
   assign stage_addr = stage_addr_ff;
   assign rsp_valid  = rsp_valid_ff;

   `GSLRT_ASSERT_NEXT(a_flush_emits, clock, reset, state_ff == ST_FLUSH, rsp_valid_ff,
      "result strobe missing after the backward pass")
   `GSLRT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff,
      "result strobe lasted more than one cycle")
   `GSLRT_ASSERT_NOW(a_sweep_in_grid, clock, reset,
      state_ff == ST_FWD || state_ff == ST_BWD,
      row_ff < rows_eff && col_ff < cols_eff,
      "sweep position outside the grid")

endmodule

// File: src/gslrt_relax.sv
// Relaxation datapath: raises one cell against its scan neighbors, writes it
// back and accumulates the saturating raise total. Depends on gslrt_pkg.
`include "grid_slope_limit_raise_total_unit_assert.svh"

module gslrt_relax #(
   parameter int HEIGHT_BITS = gslrt_pkg::HEIGHT_BITS_DEFAULT,
   parameter int ADDR_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gslrt_pkg::stage_type              stage,
   input  logic [ADDR_BITS-1:0]              stage_addr,
   input  logic [2*HEIGHT_BITS-1:0]          rd_own,
   input  logic [2*HEIGHT_BITS-1:0]          rd_nb,
   output logic                              wr_en,
   output logic [ADDR_BITS-1:0]              wr_addr,
   output logic [2*HEIGHT_BITS-1:0]          wr_data,
   output logic [gslrt_pkg::TOTAL_BITS-1:0]  total
);

   localparam int SW = gslrt_pkg::TOTAL_BITS + 1;

   // Raise dst to src - 1 when src exceeds it by more than one.
   function automatic logic [HEIGHT_BITS-1:0] pull_up(input logic [HEIGHT_BITS-1:0] dst,
                                                      input logic [HEIGHT_BITS-1:0] src);
      logic [HEIGHT_BITS-1:0] res;
      res = dst;
      if (src > dst && (src - dst) > HEIGHT_BITS'(1)) begin
         res = src - HEIGHT_BITS'(1);
      end
      return res;
   endfunction

   logic [HEIGHT_BITS-1:0] last_ff;
   logic [gslrt_pkg::TOTAL_BITS-1:0] sum_ff, sum_in;
   logic [HEIGHT_BITS-1:0] own_work, own_height, nb_work, b_src, step_b, relaxed, raise;
   logic [SW-1:0]          sum_x;

   assign own_work   = rd_own[HEIGHT_BITS-1:0];
   assign own_height = rd_own[2*HEIGHT_BITS-1:HEIGHT_BITS];
   assign nb_work    = rd_nb[HEIGHT_BITS-1:0];

   // With a single column the row neighbor is the cell finished in the previous cycle,
   // whose value has not reached the memory read yet.
   assign b_src   = stage.nb_is_last ? last_ff : nb_work;
   assign step_b  = stage.has_b ? pull_up(own_work, b_src) : own_work;
   assign relaxed = stage.has_a ? pull_up(step_b, last_ff) : step_b;
   assign raise   = relaxed - own_height;
   assign sum_x   = SW'(sum_ff) + SW'(raise);

   always_comb begin
      sum_in = sum_ff;
      if (stage.sum_clear) begin
         sum_in = '0;
      end else if (stage.valid && stage.backward) begin
         sum_in = sum_x[SW-1] ? '1 : sum_x[SW-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      if (stage.valid) begin
         last_ff <= relaxed;
      end
   end

   assign wr_en   = stage.valid;
   assign wr_addr = stage_addr;
   assign wr_data = {own_height, relaxed};
   assign total   = sum_ff;

   `GSLRT_ASSERT_NEXT(a_sum_monotonic, clock, reset, stage.valid && stage.backward,
      sum_ff >= $past(sum_ff), "raise total decreased during the backward pass")
   `GSLRT_ASSERT_NOW(a_never_lowered, clock, reset, stage.valid, relaxed >= own_height,
      "a cell was written below its loaded height")

endmodule

// File: src/grid_slope_limit_raise_total_unit.sv
// Top level of the grid slope limit raise total unit.
// Depends on gslrt_pkg, gslrt_ram, gslrt_ctrl and gslrt_relax.
//
//   channel   handshake          payload
//   request   start / busy       req_cell_height[19:0]
//   response  rsp_valid strobe   rsp_total_raise[31:0]
//   csr       csr_wr_en          csr_index[1:0], csr_wr_data[6:0]
//
// A request is taken when start is high and busy is low; cells arrive in raster order.
// After the last cell of an R x C grid, busy stays high through a forward and a
// backward pass, each followed by a write-back state (ST_GAP, ST_FLUSH), with one grid
// memory read-modify-write per cell per pass. The rsp_valid strobe follows for one
// cycle, in which busy is already low. Synchronous active-high reset; no memory clear.
module grid_slope_limit_raise_total_unit #(
   parameter int MAX_ROWS    = gslrt_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS    = gslrt_pkg::MAX_COLS_DEFAULT,
   parameter int HEIGHT_BITS = gslrt_pkg::HEIGHT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gslrt_pkg::CELL_HEIGHT_BITS-1:0] req_cell_height,
   output logic                                 rsp_valid,
   output logic [gslrt_pkg::TOTAL_BITS-1:0]     rsp_total_raise,
   input  logic                                 csr_wr_en,
   input  logic [gslrt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gslrt_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int WORD_BITS = 2 * HEIGHT_BITS;

   logic                   load_we, relax_we, mem_we;
   logic [ADDR_BITS-1:0]   issue_addr, nb_addr, stage_addr, relax_addr, mem_addr;
   logic [WORD_BITS-1:0]   relax_data, mem_data, rd_own, rd_nb;
   logic [HEIGHT_BITS-1:0] height;
   gslrt_pkg::stage_type   stage;

   // Each memory word holds the loaded height and the working height of one cell.
   assign height   = HEIGHT_BITS'(req_cell_height);
   assign mem_we   = load_we | relax_we;
   assign mem_addr = load_we ? issue_addr : relax_addr;
   assign mem_data = load_we ? {height, height} : relax_data;

   gslrt_ram #(
      .WIDTH     (WORD_BITS),
      .DEPTH     (CELLS),
      .ADDR_BITS (ADDR_BITS)
   ) u_grid (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_addr),
      .wr_data   (mem_data),
      .rd_addr_a (issue_addr),
      .rd_data_a (rd_own),
      .rd_addr_b (nb_addr),
      .rd_data_b (rd_nb)
   );

   gslrt_ctrl #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ADDR_BITS (ADDR_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .start       (start),
      .busy        (busy),
      .load_we     (load_we),
      .issue_addr  (issue_addr),
      .nb_addr     (nb_addr),
      .stage       (stage),
      .stage_addr  (stage_addr),
      .rsp_valid   (rsp_valid)
   );

   gslrt_relax #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_relax (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .stage_addr (stage_addr),
      .rd_own     (rd_own),
      .rd_nb      (rd_nb),
      .wr_en      (relax_we),
      .wr_addr    (relax_addr),
      .wr_data    (relax_data),
      .total      (rsp_total_raise)
   );

endmodule
